FILE: hw/rtl/bsw_pkg.sv
// ----------------------------------------------------------------------------
// bsw_pkg
// Shared types and constants of the B-spline basis weight block.
// ----------------------------------------------------------------------------
package bsw_pkg;

  localparam int unsigned ONE_Q16 = 65536;

  typedef enum logic {
    CFG_OFFSET = 1'b0,
    CFG_SCALE  = 1'b1
  } cfg_idx_t;

  typedef logic [16:0] wgt_t;

endpackage

FILE: hw/rtl/bspline_basis_weights.sv
// A sample passes the diff, product, z clamp and recursion stages to the output
// serializer: BINS weights, one per cycle while out_tready is high, the next sample
// after the last weight; the pipeline stages take a new sample in every cycle they move.
// Reset: synchronous active-low rst_n clears valids, offset to 0, scale to 1.0.
// ----------------------------------------------------------------------------
// bspline_basis_weights
// Maps each sample onto an open uniform knot range and emits the B-spline
// basis weights of order ORDER, one per output transaction.
// ----------------------------------------------------------------------------
module bspline_basis_weights #(
  parameter int ORDER = 3,
  parameter int BINS  = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] basis_index, [20:4] weight, pad
  output logic        out_tlast   // last_weight
);
  import bsw_pkg::*;

  localparam int NB  = BINS + ORDER - 1;
  localparam int TOPK = BINS - ORDER + 1;
  localparam int ZW  = 22;

  function automatic logic [4:0] knot(input int i);
    if (i < ORDER) return 5'd0;
    if (i <= BINS - 1) return 5'(i - ORDER + 1);
    return 5'(TOPK);
  endfunction

  logic signed [15:0] off_r;
  logic [23:0]        scl_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      scl_r <= 24'(ONE_Q16);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OFFSET: off_r <= cfg_data[15:0];
        CFG_SCALE:  scl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline: s0 diff, s1 product, s2 z clamp, s3..: recursion levels
  localparam int NS = 2 + ORDER;
  logic [NS-1:0] v_r;
  logic          adv [NS];
  logic          buf_free;

  logic signed [16:0] d_r;
  logic signed [41:0] p_r;
  logic [ZW-1:0]      z_r [NS+1];
  wgt_t               b_r [NS+1][NB];

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || buf_free;
    for (int s = NS - 2; s >= 0; s--) adv[s] = !v_r[s] || adv[s+1];
  end
  assign in_tready = adv[0];

  // blend factors per level
  wgt_t wb [ORDER][NB+1];
  for (genvar l = 1; l < ORDER; l++) begin : g_l
    for (genvar j = 0; j <= NB - l; j++) begin : g_j
      bsw_blend #(.ZW(ZW)) u_bl (
        .z(z_r[2+l]), .klo(knot(j)), .span(knot(j+l) - knot(j)), .w(wb[l][j])
      );
    end
  end

  logic [34:0] acc [ORDER][NB];
  always_comb begin
    for (int l = 0; l < ORDER; l++)
      for (int j = 0; j < NB; j++) acc[l][j] = '0;
    for (int l = 1; l < ORDER; l++)
      for (int j = 0; j < NB - l; j++) begin
        acc[l][j] = 35'(wb[l][j]) * 35'(b_r[2+l][j])
                  + 35'(17'(ONE_Q16) - wb[l][j+1]) * 35'(b_r[2+l][j+1])
                  + 35'd32768;
      end
  end

  logic [41:0] top_c;
  assign top_c = 42'(TOPK) << 16;

  logic [ZW-1:0] z3_nxt;
  wgt_t          b3_nxt [NB];
  always_comb begin
    for (int j = 0; j < NB; j++) b3_nxt[j] = '0;
    if (p_r[41]) begin
      z3_nxt = '0;
      b3_nxt[ORDER-1] = wgt_t'(ONE_Q16);
    end else if (p_r >= $signed(top_c)) begin
      z3_nxt = ZW'(top_c);
      b3_nxt[BINS-1] = wgt_t'(ONE_Q16);
    end else begin
      z3_nxt = p_r[ZW-1:0];
      for (int j = 0; j < NB; j++)
        if ((j == NB - 1 || (42'(knot(j+1)) << 16) > p_r) &&
            (j == 0 || (42'(knot(j)) << 16) <= p_r))
          b3_nxt[j] = wgt_t'(ONE_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else begin
      if (adv[0]) v_r[0] <= in_tvalid;
      for (int s = 1; s < NS; s++) if (adv[s]) v_r[s] <= v_r[s-1];
    end
    if (adv[0]) d_r <= 17'($signed(in_tdata)) - 17'(off_r);
    if (adv[1]) p_r <= 42'(d_r) * $signed({18'd0, scl_r});
    if (adv[2]) begin
      z_r[3] <= z3_nxt;
      for (int j = 0; j < NB; j++) b_r[3][j] <= b3_nxt[j];
    end
    for (int s = 4; s < NS; s++) if (adv[s-1]) z_r[s] <= z_r[s-1];
    for (int s = 4; s <= NS; s++) if (adv[s-1]) begin
      for (int j = 0; j < NB; j++) begin
        if (j < NB - (s - 3)) begin
          b_r[s][j] <= (acc[s-3][j][34:16] > 19'(ONE_Q16)) ? wgt_t'(ONE_Q16)
                                                           : acc[s-3][j][32:16];
        end else begin
          b_r[s][j] <= b_r[s-1][j];
        end
      end
    end
  end

  // output serializer with a one-sample buffer
  wgt_t       ob_r [BINS];
  logic       ob_v_r;
  logic [3:0] idx_r;
  logic       last;
  assign last     = (idx_r == 4'(BINS - 1));
  assign buf_free = !ob_v_r || (out_tready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_v_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (ob_v_r && out_tready) idx_r <= last ? '0 : idx_r + 4'd1;
      if (buf_free) ob_v_r <= v_r[NS-1];
    end
    if (buf_free && v_r[NS-1])
      for (int j = 0; j < BINS; j++) ob_r[j] <= b_r[NS][j];
  end

  assign out_tvalid = ob_v_r;
  assign out_tdata  = {3'd0, ob_r[idx_r], idx_r};
  assign out_tlast  = last;

endmodule

FILE: hw/rtl/bsw_blend.sv
// ----------------------------------------------------------------------------
// bsw_blend
// Blend factor (z - knot_lo) / span, rounded half up, clamped to 1.0.
// ----------------------------------------------------------------------------
module bsw_blend #(
  parameter int ZW = 24
) (
  input  logic [ZW-1:0] z,
  input  logic [4:0]    klo,
  input  logic [4:0]    span,
  output bsw_pkg::wgt_t w
);
  import bsw_pkg::*;

  logic signed [ZW+1:0] num;
  logic [ZW+17:0]       q;
  logic [ZW+19:0]       p3;

  always_comb begin
    num = $signed({2'b00, z}) - $signed({1'b0, klo, 16'h0000});
    q   = '0;
    p3  = '0;
    w   = '0;
    if (span == 5'd1) begin
      q = {{16{1'b0}}, num[ZW+1:0]};
    end else if (span == 5'd2) begin
      q = {{17{1'b0}}, num[ZW+1:1]} + (ZW+18)'(num[0]);
    end else if (span == 5'd3) begin
      // (num + 1) / 3 by reciprocal, exact below 2^19, clamped above
      p3 = ((ZW+20)'(num[ZW:0]) + (ZW+20)'(1)) * (ZW+20)'(349526);
      q  = (ZW+18)'(p3 >> 20);
    end
    if (span != 5'd0 && !num[ZW+1] && num != '0) begin
      w = (q > (ZW+18)'(ONE_Q16)) ? wgt_t'(ONE_Q16) : q[16:0];
    end
  end

endmodule

FILE: hw/rtl/bsw_checker.sv
// ----------------------------------------------------------------------------
// bsw_checker
// Port-level checks on the output transaction stream.
// ----------------------------------------------------------------------------
module bsw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_wmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:4] <= 17'd65536)
    else $error("weight above 1.0");
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid &&
      out_tdata[3:0] == $past(out_tdata[3:0]) + 4'd1)
    else $error("index gap");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || out_tdata[3:0] == 4'd0)
    else $error("frame start not zero");
endmodule

bind bspline_basis_weights bsw_checker u_bsw_checker (.*);
